// ===== hdl/lcd_4bit_write_sequencer_defines.svh =====
// Assertion macros for the LCD write sequencer
`ifndef LCD_4BIT_WRITE_SEQUENCER_DEFINES_SVH
`define LCD_4BIT_WRITE_SEQUENCER_DEFINES_SVH

`ifndef SYNTH
`define LCDW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lcdw assertion failed");
`define LCDW_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lcdw assertion failed");
`else
`define LCDW_ASSERT(label, clk, rst, prop)
`define LCDW_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hdl/lcdw_pkg.sv =====
package lcdw_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 20;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_POWER_UP    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE_HIGH = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SETTLE      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_CMD    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INIT_FIRST  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INIT_SECOND = 3'd5;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_INIT   = 2'd2;
  localparam logic [1:0] REQ_CURSOR = 2'd3;

  // init_step values
  localparam logic [3:0] INIT_NONE        = 4'd0;
  localparam logic [3:0] INIT_POWER       = 4'd1;
  localparam logic [3:0] INIT_FIRST_WAKE  = 4'd2;
  localparam logic [3:0] INIT_SECOND_WAKE = 4'd3;
  localparam logic [3:0] INIT_LAST_WAKE   = 4'd4;
  localparam logic [3:0] INIT_FOUR_BIT    = 4'd5;
  localparam logic [3:0] INIT_FIRST_BYTE  = 4'd6;
  localparam logic [3:0] INIT_LAST        = 4'd9;

  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT = 4'h2;
  localparam logic [7:0] BYTE_CLEAR   = 8'h01;
  localparam logic [7:0] BYTE_HOME    = 8'h02;
  localparam logic [7:0] BYTE_CURSOR  = 8'h80;

  localparam int ENABLE_BITS = 8;
  localparam int SHORT_BITS  = 16;

  typedef struct packed {
    logic [19:0]            power_up_ticks;
    logic [ENABLE_BITS-1:0] enable_high_ticks;
    logic [SHORT_BITS-1:0]  settle_ticks;
    logic [SHORT_BITS-1:0]  long_command_ticks;
    logic [SHORT_BITS-1:0]  init_first_wait_ticks;
    logic [SHORT_BITS-1:0]  init_second_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
    logic       is_data;
    logic [7:0] column;
    logic [2:0] row;
  } req_t;

  typedef struct packed {
    logic       rs_pin;
    logic       enable_pin;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic       accepted;
  } res_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_POWER   = 5'b00010,
    PH_EN_HIGH = 5'b00100,
    PH_SETTLE  = 5'b01000,
    PH_EXTRA   = 5'b10000
  } phase_t;

  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    unique case (r)
      2'd0: b = 8'h00;
      2'd1: b = 8'h40;
      2'd2: b = 8'h14;
      2'd3: b = 8'h54;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] init_byte(input logic [1:0] i);
    logic [7:0] b;
    unique case (i)
      2'd0: b = 8'h28;
      2'd1: b = 8'h0C;
      2'd2: b = 8'h06;
      2'd3: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/lcdw_cfg.sv =====
module lcdw_cfg
  import lcdw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_up_ticks         <= 20'd40000;
      cfg.enable_high_ticks      <= 8'd1;
      cfg.settle_ticks           <= 16'd50;
      cfg.long_command_ticks     <= 16'd2000;
      cfg.init_first_wait_ticks  <= 16'd5000;
      cfg.init_second_wait_ticks <= 16'd150;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_POWER_UP:    cfg.power_up_ticks         <= cfg_data;
        CFG_ENABLE_HIGH: cfg.enable_high_ticks      <= cfg_data[ENABLE_BITS-1:0];
        CFG_SETTLE:      cfg.settle_ticks           <= cfg_data[SHORT_BITS-1:0];
        CFG_LONG_CMD:    cfg.long_command_ticks     <= cfg_data[SHORT_BITS-1:0];
        CFG_INIT_FIRST:  cfg.init_first_wait_ticks  <= cfg_data[SHORT_BITS-1:0];
        CFG_INIT_SECOND: cfg.init_second_wait_ticks <= cfg_data[SHORT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/lcdw_seq.sv =====
module lcdw_seq
  import lcdw_pkg::*;
#(
  parameter int WAIT_BITS = 20
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t req,
  input  cfg_t cfg,
  output res_t res
);
  `include "lcd_4bit_write_sequencer_defines.svh"

  typedef struct packed {
    phase_t               ph;
    logic [3:0]           init_step;
    logic [WAIT_BITS-1:0] wait_count;
    logic [7:0]           held_byte;
    logic                 held_select;
    logic                 second_half;
    logic                 rs_line;
    logic                 enable_line;
    logic [3:0]           nibble_line;
  } seq_state_t;

  seq_state_t state, state_next, s;
  logic       acc;
  logic [2:0] row_sel;
  logic [7:0] cursor_byte;

  function automatic logic [WAIT_BITS-1:0] fit(input logic [31:0] v);
    return v[WAIT_BITS-1:0];
  endfunction

  function automatic seq_state_t start_nibble(input seq_state_t si, input cfg_t c,
                                              input logic [3:0] n);
    seq_state_t r;
    logic [WAIT_BITS-1:0] w;
    r = si;
    w = fit({24'd0, (c.enable_high_ticks == '0) ? 8'd1 : c.enable_high_ticks});
    r.nibble_line = n;
    r.enable_line = 1'b1;
    r.ph = PH_EN_HIGH;
    r.wait_count = (w == '0) ? WAIT_BITS'(1) : w;
    return r;
  endfunction

  function automatic seq_state_t start_byte(input seq_state_t si, input cfg_t c,
                                            input logic [7:0] b, input logic sel);
    seq_state_t r;
    r = si;
    r.held_byte = b;
    r.held_select = sel;
    r.rs_line = sel;
    r.second_half = 1'b0;
    return start_nibble(r, c, b[7:4]);
  endfunction

  function automatic seq_state_t unit_done(input seq_state_t si, input cfg_t c);
    seq_state_t r;
    logic [3:0] ofs;
    r = si;
    if (r.init_step == INIT_NONE || r.init_step >= INIT_LAST) begin
      r.init_step = INIT_NONE;
      r.ph = PH_IDLE;
      r.wait_count = '0;
    end else begin
      r.init_step = r.init_step + 4'd1;
      ofs = r.init_step - INIT_FIRST_BYTE;
      if (r.init_step <= INIT_LAST_WAKE) begin
        r = start_nibble(r, c, NIB_WAKE);
      end else if (r.init_step == INIT_FOUR_BIT) begin
        r = start_nibble(r, c, NIB_FOUR_BIT);
      end else begin
        r = start_byte(r, c, init_byte(ofs[1:0]), 1'b0);
      end
    end
    return r;
  endfunction

  function automatic seq_state_t after_settle(input seq_state_t si, input cfg_t c);
    seq_state_t r;
    logic lone;
    logic [WAIT_BITS-1:0] ex;
    r = si;
    lone = (r.init_step >= INIT_FIRST_WAKE) && (r.init_step <= INIT_FOUR_BIT);
    ex = '0;
    if (!lone && !r.second_half) begin
      r.second_half = 1'b1;
      r = start_nibble(r, c, r.held_byte[3:0]);
    end else begin
      if (r.init_step == INIT_FIRST_WAKE) begin
        ex = fit({16'd0, c.init_first_wait_ticks});
      end else if (r.init_step == INIT_SECOND_WAKE) begin
        ex = fit({16'd0, c.init_second_wait_ticks});
      end else if (!lone && !r.held_select &&
                   (r.held_byte == BYTE_CLEAR || r.held_byte == BYTE_HOME)) begin
        ex = fit({16'd0, c.long_command_ticks});
      end
      if (ex != '0) begin
        r.ph = PH_EXTRA;
        r.wait_count = ex;
      end else begin
        r = unit_done(r, c);
      end
    end
    return r;
  endfunction

  function automatic seq_state_t wait_expired(input seq_state_t si, input cfg_t c);
    seq_state_t r;
    logic [WAIT_BITS-1:0] st;
    r = si;
    st = fit({16'd0, c.settle_ticks});
    if (r.ph == PH_EN_HIGH) begin
      r.enable_line = 1'b0;
      if (st != '0) begin
        r.ph = PH_SETTLE;
        r.wait_count = st;
      end else begin
        r = after_settle(r, c);
      end
    end else if (r.ph == PH_SETTLE) begin
      r = after_settle(r, c);
    end else begin
      r = unit_done(r, c);
    end
    return r;
  endfunction

  assign row_sel     = (req.row > 3'd3) ? 3'd0 : req.row;
  assign cursor_byte = BYTE_CURSOR | (row_base(row_sel[1:0]) + req.column);

  always_comb begin
    s = state;
    acc = 1'b0;
    if (s.ph == PH_IDLE && req.command != REQ_TICK) begin
      acc = 1'b1;
      unique case (req.command)
        REQ_TICK: ;
        REQ_WRITE: begin
          s.init_step = INIT_NONE;
          s = start_byte(s, cfg, req.byte_value, req.is_data);
        end
        REQ_INIT: begin
          s.init_step = INIT_POWER;
          s.rs_line = 1'b0;
          s.enable_line = 1'b0;
          if (fit({12'd0, cfg.power_up_ticks}) != '0) begin
            s.ph = PH_POWER;
            s.wait_count = fit({12'd0, cfg.power_up_ticks});
          end else begin
            s = unit_done(s, cfg);
          end
        end
        REQ_CURSOR: begin
          s.init_step = INIT_NONE;
          s = start_byte(s, cfg, cursor_byte, 1'b0);
        end
      endcase
    end

    res.rs_pin      = s.rs_line;
    res.enable_pin  = s.enable_line;
    res.data_nibble = s.nibble_line;
    res.busy_res    = (s.ph != PH_IDLE);
    res.accepted    = acc;

    if (s.ph != PH_IDLE) begin
      if (s.wait_count != '0) s.wait_count = s.wait_count - WAIT_BITS'(1);
      if (s.wait_count == '0) s = wait_expired(s, cfg);
    end
    state_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{ph: PH_IDLE, default: '0};
    end else if (step) begin
      state <= state_next;
    end
  end

  `LCDW_ASSERT(a_enable_only_high_phase, clk, rst,
    state.enable_line |-> state.ph == PH_EN_HIGH)
  `LCDW_ASSERT(a_idle_is_clean, clk, rst,
    state.ph == PH_IDLE |-> state.wait_count == '0 && state.init_step == INIT_NONE)
  `LCDW_ASSERT(a_busy_has_wait, clk, rst,
    state.ph != PH_IDLE |-> state.wait_count != '0)
  `LCDW_ASSERT(a_request_starts, clk, rst,
    step && state.ph == PH_IDLE && req.command != REQ_TICK |=> state.ph != PH_IDLE)
  `LCDW_ASSERT(a_init_step_range, clk, rst,
    state.init_step <= INIT_LAST)

endmodule

// ===== hdl/lcd_4bit_write_sequencer.sv =====
// Character LCD write sequencer, 4-bit bus, RW held low.
// Input channel (in_valid/in_stall/in_data): one transaction is one time tick,
// carrying a request code (tick, write byte, run init, set cursor) and its
// operands. A request is taken only while the sequencer is idle; otherwise it
// is ignored and the tick still counts.
// Output channel (out_valid/out_stall/out_data): one transaction per input
// transaction, holding the RS, E and D7..D4 levels of that tick, busy and
// whether the request was taken.
// The result register is loaded on input acceptance; one tick
// is taken every cycle while the output side keeps up. When the receiver
// stalls with a result pending, in_stall is raised and the tick count halts.
// Timings come from the configuration registers (cfg_write/cfg_index/cfg_data)
// and must be written only while idle; the block itself does not enforce this.
// Reset (synchronous) restores the default timings, returns the sequencer to
// idle with all pins low and empties the result register.
module lcd_4bit_write_sequencer
  import lcdw_pkg::*;
#(
  parameter int WAIT_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  req_t                      in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output res_t                      out_data,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t cfg;
  res_t res;
  logic take;

  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  lcdw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcdw_seq #(
    .WAIT_BITS (WAIT_BITS)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .req  (in_data),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res;
    end
  end

endmodule
